@@ rtl/sdc_pkg.sv @@
package sdc_pkg;

    localparam int PIX_W      = 8;
    localparam int RESP_W     = 14;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 32;
    localparam int ADDR_W     = 4;
    localparam int DIM_W      = 11;
    localparam int KSEL_W     = 2;
    localparam int PROD_W     = 14;
    localparam int ROWSUM_W   = 16;
    localparam int SUM_W      = 17;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;

    // separable factors of the kernels
    localparam int KDER[5] = '{1, 0, -2, 0, 1};
    localparam int KSMO[5] = '{1, 4, 6, 4, 1};
    localparam int KMIX[5] = '{1, 2, 0, -2, -1};

    typedef enum logic [KSEL_W-1:0] {
        KSEL_XX   = 2'd0,
        KSEL_YY   = 2'd1,
        KSEL_XY   = 2'd2,
        KSEL_NONE = 2'd3
    } t_ksel;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KERNEL_SEL   = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    typedef logic [PIX_W-1:0]           t_pixel;
    typedef logic [4:0][4:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
    } t_tap_mask;

    typedef struct packed {
        logic             frame_done;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
    } t_res_meta;

    typedef struct packed {
        t_res_meta                meta;
        logic signed [RESP_W-1:0] response;
    } t_result;

    typedef struct packed {
        logic prod_valid;
        logic rsum_valid;
    } t_sum_status;

    function automatic logic signed [4:0] kern_coef(input t_ksel sel, input int i, input int j);
        logic signed [4:0] c;
        case (sel)
            KSEL_XX: c = 5'(KSMO[i] * KDER[j]);
            KSEL_YY: c = 5'(KDER[i] * KSMO[j]);
            KSEL_XY: c = 5'(KMIX[i] * KMIX[j]);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/sdc_line_buf.sv @@
module sdc_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    input  sdc_pkg::t_pixel        i_px,
    output sdc_pkg::t_window       o_window
);

    localparam int WORD_W = 4 * sdc_pkg::PIX_W;

    logic [WORD_W-1:0] mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rdata;
    logic [AW-1:0]     r_wr_addr;
    sdc_pkg::t_pixel   r_px;
    logic              r_s1_valid;
    logic [WORD_W-1:0] wdata;
    sdc_pkg::t_window  r_window;
    sdc_pkg::t_window  n_window;
    logic              fwd;

    // column shifts up by one row; the new pixel goes in at the bottom
    assign wdata = {r_px, r_rdata[WORD_W-1:sdc_pkg::PIX_W]};
    // a one-pixel-wide frame reads the column that is being written back
    assign fwd   = r_s1_valid && (r_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem[r_wr_addr] <= wdata;
        end
        if (i_rd_en) begin
            r_rdata   <= fwd ? wdata : mem[i_rd_addr];
            r_wr_addr <= i_rd_addr;
            r_px      <= i_px;
        end
    end

    always_comb begin
        n_window = r_window;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_window[i][j] = r_window[i][j+1];
            end
        end
        for (int i = 0; i < 4; i++) begin
            n_window[i][4] = r_rdata[i*sdc_pkg::PIX_W +: sdc_pkg::PIX_W];
        end
        n_window[4][4] = r_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_window   <= '0;
        end else begin
            r_s1_valid <= i_rd_en;
            if (r_s1_valid) begin
                r_window <= n_window;
            end
        end
    end

    assign o_window = r_window;

endmodule

@@ rtl/sdc_kernel_sum.sv @@
module sdc_kernel_sum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sdc_pkg::t_window      i_window,
    input  sdc_pkg::t_tap_mask    i_mask,
    input  sdc_pkg::t_res_meta    i_meta,
    input  sdc_pkg::t_ksel        i_ksel,
    output sdc_pkg::t_sum_status  o_status,
    output logic                  o_valid,
    output sdc_pkg::t_result      o_result
);

    logic signed [sdc_pkg::PROD_W-1:0]   r_prod [5][5];
    logic signed [sdc_pkg::PROD_W-1:0]   n_prod [5][5];
    logic signed [sdc_pkg::ROWSUM_W-1:0] r_rsum [5];
    logic signed [sdc_pkg::ROWSUM_W-1:0] n_rsum [5];
    logic signed [sdc_pkg::SUM_W-1:0]    total;
    logic                                r_prod_valid;
    logic                                r_rsum_valid;
    sdc_pkg::t_res_meta                  r_prod_meta;
    sdc_pkg::t_res_meta                  r_rsum_meta;

    // taps outside the frame contribute nothing
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (i_mask.row[i] && i_mask.col[j]) begin
                    n_prod[i][j] = sdc_pkg::PROD_W'($signed({1'b0, i_window[i][j]}))
                                 * sdc_pkg::PROD_W'(sdc_pkg::kern_coef(i_ksel, i, j));
                end else begin
                    n_prod[i][j] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            n_rsum[i] = '0;
            for (int j = 0; j < 5; j++) begin
                n_rsum[i] = n_rsum[i] + sdc_pkg::ROWSUM_W'(r_prod[i][j]);
            end
        end
        total = '0;
        for (int i = 0; i < 5; i++) begin
            total = total + sdc_pkg::SUM_W'(r_rsum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_prod      <= n_prod;
            r_prod_meta <= i_meta;
        end
        if (r_prod_valid) begin
            r_rsum      <= n_rsum;
            r_rsum_meta <= r_prod_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_rsum_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
            r_rsum_valid <= r_prod_valid;
        end
    end

    assign o_status.prod_valid = r_prod_valid;
    assign o_status.rsum_valid = r_rsum_valid;
    assign o_valid             = r_rsum_valid;
    assign o_result.meta       = r_rsum_meta;
    assign o_result.response   = sdc_pkg::RESP_W'(total);

endmodule

@@ rtl/sdc_out_fifo.sv @@
module sdc_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  sdc_pkg::t_result              i_data,
    input  logic                          i_pop,
    output logic                          o_valid,
    output sdc_pkg::t_result              o_data,
    output logic [sdc_pkg::FIFO_AW:0]     o_count
);

    sdc_pkg::t_result              fifo_q [sdc_pkg::FIFO_DEPTH];
    logic [sdc_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [sdc_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [sdc_pkg::FIFO_AW:0]     r_count;
    logic                          do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            fifo_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = fifo_q[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ rtl/second_derivative_conv5x5.sv @@
// 5x5 second-derivative filter over an 8-bit grey raster stream.
// Input: s_axis carries one pixel per request in raster order. After each
// frame the source sends 2*width+2 padding requests (pixel ignored) so the
// last rows drain. Output: m_axis carries one response per frame pixel with
// its row and column; tlast marks the last response of a frame.
// Registers (APB, byte address 4*i): frame_width, frame_height,
// kernel_select (0 xx, 1 yy, 2 xy). A write to any of these registers
// restarts the frame position; write only while the block is idle.
// Throughput: one pixel per clock while s_axis_tready is high. Each request
// does one read and one write of its column in the line store (one word of
// four rows per column), so the column memory port sets the rate.
// Path: the response for pixel p starts with the request 2*width+2 after p
// and passes line store read, window, product stage, row-sum stage, queue.
// Stall: an 8-entry result queue decouples the sides; s_axis_tready drops
// only when the queue plus in-flight requests could overflow it.
// Reset: counters, valid bits, window clear at once; line store contents are
// undefined, unwritten words reach only masked taps. No clearing pass.
module second_derivative_conv5x5 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sdc_pkg::S_DATA_W-1:0]     s_axis_tdata,  // [7:0] pixel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [13:0] response, [23:14] center_row, [33:24] center_col, [39:34] zero
    output logic [sdc_pkg::M_DATA_W-1:0]     m_axis_tdata,
    output logic                             m_axis_tlast,  // frame_done
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdc_pkg::ADDR_W-1:0]       paddr,
    input  logic [sdc_pkg::CFG_W-1:0]        pwdata,
    output logic [sdc_pkg::CFG_W-1:0]        prdata,
    output logic                             pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = HW + 2;

    // configuration
    logic [sdc_pkg::DIM_W-1:0]  r_frame_width;
    logic [sdc_pkg::DIM_W-1:0]  r_frame_height;
    logic [sdc_pkg::KSEL_W-1:0] r_kernel_select;
    logic                       cfg_wr;
    sdc_pkg::t_reg_idx          cfg_idx;
    logic                       cfg_hit;

    logic [WW-1:0] w;
    logic [HW-1:0] h;

    // frame position
    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic          in_acc;
    logic [2:0]    back;
    logic          emit;
    logic [RW-1:0] r0;
    logic [WW-1:0] c0;
    logic          done;
    logic [WW-1:0] col_x;
    logic [WW-1:0] col_inc;
    sdc_pkg::t_pixel px;

    // stage 1: line store read in flight
    logic          r_s1_valid;
    logic          r_s1_emit;
    logic          r_s1_done;
    logic [RW-1:0] r_s1_r0;
    logic [WW-1:0] r_s1_c0;
    sdc_pkg::t_tap_mask s1_mask;
    logic [RW:0]   r0_x;
    logic [WW:0]   c0_x;
    logic [RW:0]   h_x;
    logic [WW:0]   w_x;

    // stage 2: window holds the item
    logic               r_s2_valid;
    sdc_pkg::t_tap_mask r_s2_mask;
    sdc_pkg::t_res_meta r_s2_meta;

    sdc_pkg::t_window     window;
    sdc_pkg::t_sum_status sum_status;
    logic                 sum_valid;
    sdc_pkg::t_result     sum_result;
    sdc_pkg::t_result     out_data;
    logic [sdc_pkg::FIFO_AW:0]   out_count;
    logic [sdc_pkg::FIFO_AW+1:0] committed;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = sdc_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_hit = cfg_wr && (cfg_idx != sdc_pkg::REG_UNUSED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= sdc_pkg::RST_FRAME_WIDTH;
            r_frame_height  <= sdc_pkg::RST_FRAME_HEIGHT;
            r_kernel_select <= sdc_pkg::KSEL_XX;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sdc_pkg::REG_FRAME_WIDTH:  r_frame_width   <= pwdata[sdc_pkg::DIM_W-1:0];
                sdc_pkg::REG_FRAME_HEIGHT: r_frame_height  <= pwdata[sdc_pkg::DIM_W-1:0];
                sdc_pkg::REG_KERNEL_SEL:   r_kernel_select <= pwdata[sdc_pkg::KSEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sdc_pkg::REG_FRAME_WIDTH:  prdata = sdc_pkg::CFG_W'(r_frame_width);
            sdc_pkg::REG_FRAME_HEIGHT: prdata = sdc_pkg::CFG_W'(r_frame_height);
            sdc_pkg::REG_KERNEL_SEL:   prdata = sdc_pkg::CFG_W'(r_kernel_select);
            default:                   prdata = '0;
        endcase
    end

    // zero means one, anything above the maximum is the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h = HW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(r_frame_height);
        end
    end

    // ---------------- frame position ----------------
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign col_x  = WW'(r_col);

    // center lies 2*w+2 items back: two rows up and two columns left,
    // folded for frames narrower than three columns
    always_comb begin
        if (w == WW'(1)) begin
            back = 3'd4;
            c0   = '0;
        end else if (w == WW'(2)) begin
            back = 3'd3;
            c0   = col_x;
        end else if (col_x >= WW'(2)) begin
            back = 3'd2;
            c0   = col_x - WW'(2);
        end else begin
            back = 3'd3;
            c0   = col_x + w - WW'(2);
        end
        emit = (r_row >= RW'(back));
        r0   = r_row - RW'(back);
        done = emit && ((r0 > RW'(h) - RW'(1))
                     || ((r0 == RW'(h) - RW'(1)) && (c0 >= w - WW'(1))));
        px   = (r_row < RW'(h)) ? s_axis_tdata[sdc_pkg::PIX_W-1:0] : '0;
    end

    assign col_inc = col_x + WW'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (done) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc == w) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = AW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_emit <= emit;
            r_s1_done <= done;
            r_s1_r0   <= r0;
            r_s1_c0   <= c0;
        end
    end

    assign r0_x = (RW+1)'(r_s1_r0);
    assign c0_x = (WW+1)'(r_s1_c0);
    assign h_x  = (RW+1)'(h);
    assign w_x  = (WW+1)'(w);

    always_comb begin
        s1_mask.row[0] = (r0_x >= (RW+1)'(2));
        s1_mask.row[1] = (r0_x >= (RW+1)'(1));
        s1_mask.row[2] = (r0_x < h_x);
        s1_mask.row[3] = (r0_x + (RW+1)'(1) < h_x);
        s1_mask.row[4] = (r0_x + (RW+1)'(2) < h_x);
        s1_mask.col[0] = (c0_x >= (WW+1)'(2));
        s1_mask.col[1] = (c0_x >= (WW+1)'(1));
        s1_mask.col[2] = (c0_x < w_x);
        s1_mask.col[3] = (c0_x + (WW+1)'(1) < w_x);
        s1_mask.col[4] = (c0_x + (WW+1)'(2) < w_x);
    end

    sdc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_px      (px),
        .o_window  (window)
    );

    // ---------------- stage 2 ----------------
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_emit) begin
            r_s2_mask            <= s1_mask;
            r_s2_meta.frame_done <= r_s1_done;
            r_s2_meta.center_row <= sdc_pkg::POS_W'(r_s1_r0);
            r_s2_meta.center_col <= sdc_pkg::POS_W'(r_s1_c0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    sdc_kernel_sum u_kernel_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .i_window (window),
        .i_mask   (r_s2_mask),
        .i_meta   (r_s2_meta),
        .i_ksel   (sdc_pkg::t_ksel'(r_kernel_select)),
        .o_status (sum_status),
        .o_valid  (sum_valid),
        .o_result (sum_result)
    );

    sdc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_valid),
        .i_data  (sum_result),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data),
        .o_count (out_count)
    );

    // every request in flight may still land in the queue
    assign committed = (sdc_pkg::FIFO_AW+2)'(out_count)
                     + (sdc_pkg::FIFO_AW+2)'(r_s1_valid)
                     + (sdc_pkg::FIFO_AW+2)'(r_s2_valid)
                     + (sdc_pkg::FIFO_AW+2)'(sum_status.prod_valid)
                     + (sdc_pkg::FIFO_AW+2)'(sum_status.rsum_valid);

    assign s_axis_tready = (committed < (sdc_pkg::FIFO_AW+2)'(sdc_pkg::FIFO_DEPTH));

    assign m_axis_tdata = sdc_pkg::M_DATA_W'({out_data.meta.center_col,
                                              out_data.meta.center_row,
                                              out_data.response});
    assign m_axis_tlast = out_data.meta.frame_done;

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int RANDOM_ITEMS   = 1730;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    // separable factors of the three derivative kernels
    localparam int DERIV[5]  = '{1, 0, -2, 0, 1};
    localparam int SMOOTH[5] = '{1, 4, 6, 4, 1};
    localparam int MIXED[5]  = '{1, 2, 0, -2, -1};

    typedef struct {
        logic [7:0]  pixel;
        int unsigned gap;
        bit          drain;
    } t_pix_req;

    typedef struct {
        logic signed [sdc_pkg::RESP_W-1:0] response;
        logic [sdc_pkg::POS_W-1:0]         row;
        logic [sdc_pkg::POS_W-1:0]         col;
        logic                              done;
    } t_hess_out;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sdc_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;    // [7:0] pixel
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [13:0] response, [23:14] center_row, [33:24] center_col, [39:34] zero
    logic [sdc_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic                           m_axis_tlast;          // frame_done
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [sdc_pkg::ADDR_W-1:0]     paddr         = '0;
    logic [sdc_pkg::CFG_W-1:0]      pwdata        = '0;
    logic [sdc_pkg::CFG_W-1:0]      prdata;
    logic                           pready;

    second_derivative_conv5x5 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // filter mirror: registers, line stores, window and raster position
    logic [sdc_pkg::DIM_W-1:0] cfg_width;
    logic [sdc_pkg::DIM_W-1:0] cfg_height;
    sdc_pkg::t_ksel            cfg_kernel;
    logic [7:0]                line_mem [0:4*MAX_W-1];
    logic [7:0]                win [0:4][0:4];
    int unsigned               pos_col;
    int unsigned               pos_row;

    t_pix_req    pix_q[$];
    t_hess_out   resp_q[$];
    int unsigned pixels_queued;
    int unsigned pixels_accepted;
    int unsigned responses_checked;
    int unsigned frames_closed;
    int unsigned reg_writes;
    int unsigned errors;
    int unsigned hold_asks;
    int unsigned holds_done;
    int unsigned quiet_cycles;
    bit          kernels_seen [4];

    function automatic int unsigned clamp_dim(input logic [sdc_pkg::DIM_W-1:0] v,
                                              input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return 32'(v);
    endfunction

    function automatic int tap_weight(input sdc_pkg::t_ksel k, input int i, input int j);
        case (k)
            sdc_pkg::KSEL_XX: return SMOOTH[i] * DERIV[j];
            sdc_pkg::KSEL_YY: return DERIV[i] * SMOOTH[j];
            sdc_pkg::KSEL_XY: return MIXED[i] * MIXED[j];
            default:          return 0;
        endcase
    endfunction

    // Shift one request into the window and line stores; queue the response
    // for the pixel 2*width+2 requests back, once the warm-up is over.
    function automatic void filter_pixel(input logic [7:0] pin);
        int unsigned w, h, c, r, t, lag, u, r0, c0, base;
        int          sum, rr, cc;
        logic [7:0]  px;
        t_hess_out   e;
        w = clamp_dim(cfg_width, MAX_W);
        h = clamp_dim(cfg_height, MAX_H);
        r = pos_row;
        c = pos_col;
        px = (r < h) ? pin : 8'd0;
        if (c >= w) c = 0;
        base = c * 4;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                win[i][j] = win[i][j+1];
        for (int i = 0; i < 4; i++)
            win[i][4] = line_mem[base+i];
        win[4][4] = px;
        for (int i = 0; i < 3; i++)
            line_mem[base+i] = line_mem[base+i+1];
        line_mem[base+3] = px;
        t   = r * w + c;
        lag = 2 * w + 2;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        pos_col = c;
        pos_row = r;
        if (t < lag) return;
        u   = t - lag;
        r0  = u / w;
        c0  = u % w;
        sum = 0;
        for (int i = 0; i < 5; i++) begin
            rr = int'(r0) + i - 2;
            if (rr < 0 || rr >= int'(h)) continue;
            for (int j = 0; j < 5; j++) begin
                cc = int'(c0) + j - 2;
                if (cc < 0 || cc >= int'(w)) continue;
                sum += int'(win[i][j]) * tap_weight(cfg_kernel, i, j);
            end
        end
        e.response = sum[sdc_pkg::RESP_W-1:0];
        e.row      = r0[sdc_pkg::POS_W-1:0];
        e.col      = c0[sdc_pkg::POS_W-1:0];
        e.done     = (u >= h * w - 1);
        if (e.done) begin
            pos_col = 0;
            pos_row = 0;
        end
        resp_q.push_back(e);
    endfunction

    // pixel source
    always @(posedge i_clk) begin : pixel_driver
        int unsigned gap_cnt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_cnt = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                filter_pixel(s_axis_tdata);
                pixels_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pix_q.size() != 0 && gap_cnt >= pix_q[0].gap &&
                    !(pix_q[0].drain && resp_q.size() != 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pix_q[0].pixel;
                    void'(pix_q.pop_front());
                    gap_cnt = 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (pix_q.size() != 0 && gap_cnt < pix_q[0].gap) gap_cnt++;
                end
            end
        end
    end

    // response sink and checker
    always @(posedge i_clk) begin : response_monitor
        t_hess_out   e;
        int unsigned rx_wait;
        int unsigned rx_hold;
        int unsigned rx_style;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait  = 0;
            rx_hold  = 0;
            rx_style = 2;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (resp_q.size() == 0) begin
                    $error("response with nothing pending: tdata %h", m_axis_tdata);
                    errors++;
                end else begin
                    e = resp_q.pop_front();
                    if (m_axis_tdata[13:0] !== e.response) begin
                        $error("response: expected %0d, got %0d",
                               e.response, $signed(m_axis_tdata[13:0]));
                        errors++;
                    end
                    if (m_axis_tdata[23:14] !== e.row) begin
                        $error("center_row: expected %0d, got %0d", e.row, m_axis_tdata[23:14]);
                        errors++;
                    end
                    if (m_axis_tdata[33:24] !== e.col) begin
                        $error("center_col: expected %0d, got %0d", e.col, m_axis_tdata[33:24]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.done) begin
                        $error("frame_done: expected %0d, got %0d", e.done, m_axis_tlast);
                        errors++;
                    end
                end
                if (m_axis_tlast) frames_closed++;
                responses_checked++;
                if (responses_checked % 64 == 0) rx_style = $urandom_range(0, 2);
                case (rx_style)
                    0:       rx_wait = 0;
                    1:       rx_wait = $urandom_range(0, 2);
                    default: rx_wait = $urandom_range(0, 8);
                endcase
            end
            if (hold_asks != holds_done) begin
                holds_done++;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic reg_write(input sdc_pkg::t_reg_idx idx,
                             input logic [sdc_pkg::DIM_W-1:0] val);
        logic [sdc_pkg::CFG_W-1:0] word;
        word = $urandom;
        if (idx == sdc_pkg::REG_KERNEL_SEL)
            word[sdc_pkg::KSEL_W-1:0] = val[sdc_pkg::KSEL_W-1:0];
        else
            word[sdc_pkg::DIM_W-1:0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            sdc_pkg::REG_FRAME_WIDTH:  cfg_width  = word[sdc_pkg::DIM_W-1:0];
            sdc_pkg::REG_FRAME_HEIGHT: cfg_height = word[sdc_pkg::DIM_W-1:0];
            sdc_pkg::REG_KERNEL_SEL:
                cfg_kernel = sdc_pkg::t_ksel'(word[sdc_pkg::KSEL_W-1:0]);
            default:                   ;
        endcase
        if (idx != sdc_pkg::REG_UNUSED) begin
            pos_col = 0;
            pos_row = 0;
        end
        reg_writes++;
        @(negedge i_clk);
    endtask

    // pix_style: 0 random, 1 black/white only, 2 flat; gap_style: 0 none, 1 short, 2 full
    function automatic void queue_pixels(input int unsigned count, input int unsigned pix_style,
                                         input int unsigned gap_style, input int drain_at);
        t_pix_req    req;
        logic [7:0]  flat;
        flat = 8'($urandom_range(0, 255));
        for (int n = 0; n < count; n++) begin
            case (pix_style)
                0:       req.pixel = 8'($urandom_range(0, 255));
                1:       req.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: req.pixel = flat;
            endcase
            case (gap_style)
                0:       req.gap = 0;
                1:       req.gap = $urandom_range(0, 2);
                default: req.gap = $urandom_range(0, 8);
            endcase
            req.drain = (n == drain_at);
            pix_q.push_back(req);
        end
        pixels_queued += count;
        kernels_seen[cfg_kernel] = 1'b1;
    endfunction

    task automatic wait_idle();
        while (pixels_accepted != pixels_queued || resp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned w, h, cnt, frames, random_items, pix_style, gap_style, start;
        int          drain_at;
        t_pix_req    req;

        cfg_width  = sdc_pkg::RST_FRAME_WIDTH;
        cfg_height = sdc_pkg::RST_FRAME_HEIGHT;
        cfg_kernel = sdc_pkg::KSEL_XX;
        pos_col    = 0;
        pos_row    = 0;
        for (int i = 0; i < 4 * MAX_W; i++) line_mem[i] = 8'd0;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                win[i][j] = 8'd0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // one-row frame of alternating extremes; padding carries 255 to show it is ignored
        reg_write(sdc_pkg::REG_FRAME_WIDTH, 11'd5);
        reg_write(sdc_pkg::REG_FRAME_HEIGHT, 11'd1);
        reg_write(sdc_pkg::REG_KERNEL_SEL, 11'(sdc_pkg::KSEL_XX));
        for (int n = 0; n < 17; n++) begin
            req.pixel = (n < 5 && n % 2 == 1) ? 8'h00 : 8'hFF;
            req.gap   = 0;
            req.drain = 1'b0;
            pix_q.push_back(req);
        end
        pixels_queued += 17;
        wait_idle();

        // zero width and height clamp to a single pixel
        reg_write(sdc_pkg::REG_FRAME_WIDTH, 11'd0);
        reg_write(sdc_pkg::REG_FRAME_HEIGHT, 11'd0);
        reg_write(sdc_pkg::REG_KERNEL_SEL, 11'(sdc_pkg::KSEL_YY));
        queue_pixels(5, 1, 0, -1);
        wait_idle();

        // long receiver stall mid-frame: the result queue fills and the input stalls
        reg_write(sdc_pkg::REG_FRAME_WIDTH, 11'd12);
        reg_write(sdc_pkg::REG_FRAME_HEIGHT, 11'd8);
        reg_write(sdc_pkg::REG_KERNEL_SEL, 11'(sdc_pkg::KSEL_XY));
        start = pixels_accepted;
        queue_pixels(12 * 8 + 2 * 12 + 2, 0, 0, -1);
        while (pixels_accepted < start + 40) @(negedge i_clk);
        hold_asks++;
        wait_idle();

        // oversized height, cut short; the source waits for the sink to drain mid-frame
        reg_write(sdc_pkg::REG_FRAME_WIDTH, 11'd5);
        reg_write(sdc_pkg::REG_FRAME_HEIGHT, 11'h7FF);
        reg_write(sdc_pkg::REG_KERNEL_SEL, 11'(sdc_pkg::KSEL_YY));
        queue_pixels(80, 0, 2, 40);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       w = $urandom_range(0, 4);
                    1:       w = $urandom_range(13, 40);
                    default: w = $urandom_range(5, 12);
                endcase
                reg_write(sdc_pkg::REG_FRAME_WIDTH, w[sdc_pkg::DIM_W-1:0]);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       h = 0;
                    1:       h = $urandom_range(7, 16);
                    default: h = $urandom_range(1, 6);
                endcase
                reg_write(sdc_pkg::REG_FRAME_HEIGHT, h[sdc_pkg::DIM_W-1:0]);
            end
            if ($urandom_range(0, 2) != 0)
                reg_write(sdc_pkg::REG_KERNEL_SEL, 11'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0)
                reg_write(sdc_pkg::REG_UNUSED, 11'($urandom_range(0, 2047)));
            w = clamp_dim(cfg_width, MAX_W);
            h = clamp_dim(cfg_height, MAX_H);
            frames    = $urandom_range(1, 3);
            pix_style = $urandom_range(0, 2);
            gap_style = $urandom_range(0, 2);
            for (int f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
                cnt = w * h + 2 * w + 2;
                // now and then stop mid-frame; the next write to a used register restarts it
                if ($urandom_range(0, 5) == 0) cnt = $urandom_range(1, cnt - 1);
                if (cnt > RANDOM_ITEMS - random_items) cnt = RANDOM_ITEMS - random_items;
                drain_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, cnt - 1)) : -1;
                queue_pixels(cnt, pix_style, gap_style, drain_at);
                random_items += cnt;
            end
            wait_idle();
        end

        while (pixels_accepted != pixels_queued || resp_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("covered %0d pixel requests, %0d responses in %0d closed frames",
                 pixels_accepted, responses_checked, frames_closed);
        $display("%0d register writes, kernels xx/yy/xy/none used: %0d%0d%0d%0d",
                 reg_writes, kernels_seen[0], kernels_seen[1], kernels_seen[2],
                 kernels_seen[3]);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ second_derivative_conv5x5.f @@
rtl/sdc_pkg.sv
rtl/sdc_line_buf.sv
rtl/sdc_kernel_sum.sv
rtl/sdc_out_fifo.sv
rtl/second_derivative_conv5x5.sv
verif/tb_top.sv
